>>> src/blid_pkg.sv
// ----------------------------------------------------------------------------
// blid_pkg
// Shared constants, opcodes and controller/datapath interface types for the
// bounded list core.
// ----------------------------------------------------------------------------
package blid_pkg;

  // default number of list entries
  localparam int BLID_CAPACITY = 16;

  // opcodes of an input transaction
  localparam logic [1:0] OP_INS_FRONT = 2'd0;
  localparam logic [1:0] OP_APPEND    = 2'd1;
  localparam logic [1:0] OP_DELETE    = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // input transaction taken this cycle
    logic ins_front;  // write operand ahead of the head
    logic append;     // write operand behind the tail
    logic count_dec;  // one element fewer
    logic del_write;  // move read data one place towards the front
    logic idx_inc;    // step the working index
    logic idx_clear;  // working index back to the front
    logic rd_next;    // read the entry after the working index
    logic load_out;   // capture a result into the output register
    logic out_take;   // result transaction completed
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_insert;  // input opcode is front insert
    logic is_append;  // input opcode is back append
    logic is_delete;  // input opcode is indexed delete
    logic full;       // store holds capacity elements
    logic del_ok;     // delete position is inside the list
    logic del_move;   // delete needs at least one move
    logic move_more;  // another move follows the current one
    logic out_taken;  // output register is being taken
    logic out_last;   // output register holds the final result
  } status_t;

endpackage

>>> src/blid_ram.sv
// ----------------------------------------------------------------------------
// blid_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module blid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/blid_ctrl.sv
// ----------------------------------------------------------------------------
// blid_ctrl
// Controller for the bounded list: takes a command, sequences the delete
// sweep and walks the list out one result at a time.
// ----------------------------------------------------------------------------
module blid_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  blid_pkg::status_t status,
  output blid_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DEL_RD   = 3'd1;
  localparam logic [2:0] S_DEL_WR   = 3'd2;
  localparam logic [2:0] S_EMIT_RD  = 3'd3;
  localparam logic [2:0] S_EMIT_LD  = 3'd4;
  localparam logic [2:0] S_EMIT_OUT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EMIT_RD;
          if (status.is_delete && status.del_ok) begin
            if (status.del_move) begin
              state_next = S_DEL_RD;
            end else begin
              cmd.count_dec = 1'b1;
              cmd.idx_clear = 1'b1;
            end
          end else begin
            cmd.idx_clear = 1'b1;
            if (!status.full) begin
              cmd.ins_front = status.is_insert;
              cmd.append    = status.is_append;
            end
          end
        end
      end
      S_DEL_RD: begin
        cmd.rd_next = 1'b1;
        state_next  = S_DEL_WR;
      end
      S_DEL_WR: begin
        cmd.del_write = 1'b1;
        cmd.idx_inc   = 1'b1;
        if (status.move_more) begin
          state_next = S_DEL_RD;
        end else begin
          cmd.count_dec = 1'b1;
          cmd.idx_clear = 1'b1;
          state_next    = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.load_out = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (status.out_taken) begin
          cmd.out_take = 1'b1;
          state_next   = status.out_last ? S_IDLE : S_EMIT_LD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> src/blid_datapath.sv
// ----------------------------------------------------------------------------
// blid_datapath
// Circular element store with head pointer and count, working index,
// delete move path and the output register.
// ----------------------------------------------------------------------------
module blid_datapath #(
  parameter int CAPACITY = blid_pkg::BLID_CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] operand,
  output logic signed [31:0] element_value,
  output logic               last_element,
  output logic               list_empty,
  output logic               insert_dropped,
  output logic               out_valid,
  input  logic               out_stall,
  input  blid_pkg::cmd_t     cmd,
  output blid_pkg::status_t  status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic          dropped;

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;
  logic [AW-1:0] head_dec;
  logic [CW:0]   idx_p1;
  logic [CW:0]   idx_p2;
  logic [31:0]   pos_ext;
  logic [31:0]   cnt_ext;

  // physical address of a logical position, wrapping once at capacity
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW:0] ofs);
    logic [CW+1:0] sum;
    sum = {{(CW+2-AW){1'b0}}, base} + {1'b0, ofs};
    if (sum >= (CW+2)'(CAPACITY)) begin
      sum = sum - (CW+2)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  assign head_dec = (head == '0) ? AW'(CAPACITY - 1) : head - AW'(1);
  assign idx_p1   = {1'b0, idx} + (CW+1)'(1);
  assign idx_p2   = {1'b0, idx} + (CW+1)'(2);
  assign pos_ext  = {1'b0, operand[30:0]};
  assign cnt_ext  = 32'(count);

  // status towards the controller
  always_comb begin
    status.is_insert = (opcode == blid_pkg::OP_INS_FRONT);
    status.is_append = (opcode == blid_pkg::OP_APPEND);
    status.is_delete = (opcode == blid_pkg::OP_DELETE);
    status.full      = (count == CW'(CAPACITY));
    status.del_ok    = !operand[31] && (pos_ext < cnt_ext);
    status.del_move  = (pos_ext + 32'd1) < cnt_ext;
    status.move_more = idx_p2 < {1'b0, count};
    status.out_taken = out_valid && !out_stall;
    status.out_last  = last_element;
  end

  // write port select: front insert, back append or delete move
  always_comb begin
    we    = cmd.ins_front || cmd.append || cmd.del_write;
    waddr = phys(head, {1'b0, idx});
    wdata = rdata;
    if (cmd.ins_front) begin
      waddr = head_dec;
      wdata = operand;
    end else if (cmd.append) begin
      waddr = phys(head, {1'b0, count});
      wdata = operand;
    end
  end

  // read address: working index, or the one after it during a delete
  assign raddr = cmd.rd_next ? phys(head, idx_p1) : phys(head, {1'b0, idx});

  blid_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // list control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.ins_front) begin
        head <= head_dec;
      end
      if (cmd.ins_front || cmd.append) begin
        count <= count + CW'(1);
      end else if (cmd.count_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (cmd.out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working index and drop flag
  always_ff @(posedge clk) begin
    if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.accept) begin
      idx <= CW'(operand[AW-1:0]);
    end else if (cmd.idx_inc) begin
      idx <= idx_p1[CW-1:0];
    end
    if (cmd.accept) begin
      dropped <= (status.is_insert || status.is_append) && status.full;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      element_value  <= (count == '0) ? 32'sd0 : rdata;
      last_element   <= (count == '0) || (idx_p1 == {1'b0, count});
      list_empty     <= (count == '0);
      insert_dropped <= dropped;
    end
  end

endmodule

>>> src/bounded_list_insert_delete_core.sv
// ----------------------------------------------------------------------------
// bounded_list_insert_delete_core
// Bounded ordered list of signed 32-bit values with front insert, back
// append and indexed delete; the whole list is emitted after every command.
// ----------------------------------------------------------------------------
// A command is taken when the core is idle. After it, the list is read out
// front to back from a circular store held in a RAM, one result at a time:
// a priming read, then for each result a RAM read and the output register,
// and the next result is loaded only once the last one has been taken; an
// empty list gives a single result flagged empty. A delete moves every
// element behind the deleted position one place forward through the single
// RAM port pair, a read and then a write per moved element, before the
// read-out starts. in_stall is high from acceptance until the last result
// has been taken.
module bounded_list_insert_delete_core #(
  parameter int CAPACITY = blid_pkg::BLID_CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] operand,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] element_value,
  output logic               last_element,
  output logic               list_empty,
  output logic               insert_dropped
);

  blid_pkg::cmd_t    cmd;
  blid_pkg::status_t status;

  // sequencing
  blid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // store, pointers and output register
  blid_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .opcode         (opcode),
    .operand        (operand),
    .element_value  (element_value),
    .last_element   (last_element),
    .list_empty     (list_empty),
    .insert_dropped (insert_dropped),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bounded_list_insert_delete_core. Commands go in on
// a valid/stall channel in random bursts while the result side stalls on a
// pattern of its own. A scoreboard keeps its own copy of the list, works out
// every element expected after each accepted command and checks each result
// transaction against it.
// ----------------------------------------------------------------------------
module tb;

  localparam int          SLOTS          = blid_pkg::BLID_CAPACITY;
  localparam logic [1:0]  OP_IDLE        = 2'd3;   // opcode with no command behind it
  localparam int          RANDOM_CMDS    = 360;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          SETTLE_CYCLES  = 100;

  // one element of the list as it leaves the block
  typedef struct {
    logic signed [31:0] value;
    logic               last;
    logic               empty;
    logic               dropped;
  } list_beat_t;

  // list tracker and result checker
  class list_scoreboard;
    logic signed [31:0] slot [SLOTS];
    int                 fill;
    list_beat_t         expected_beats [$];
    int                 errors;
    int                 beats_checked;
    int                 deepest;
    int                 dropped_inserts;
    int                 missed_deletes;
    int                 op_seen [4];

    function new();
      fill            = 0;
      errors          = 0;
      beats_checked   = 0;
      deepest         = 0;
      dropped_inserts = 0;
      missed_deletes  = 0;
      foreach (op_seen[j]) op_seen[j] = 0;
    endfunction

    // update the list for an accepted command and queue the whole list
    function void apply_command(logic [1:0] op, logic signed [31:0] arg);
      logic       refused;
      list_beat_t beat;
      int         i;
      refused = 1'b0;
      op_seen[op]++;
      case (op)
        blid_pkg::OP_INS_FRONT, blid_pkg::OP_APPEND: begin
          if (fill >= SLOTS) begin
            refused = 1'b1;
            dropped_inserts++;
          end else if (op == blid_pkg::OP_INS_FRONT) begin
            for (i = fill; i > 0; i--) slot[i] = slot[i - 1];
            slot[0] = arg;
            fill++;
          end else begin
            slot[fill] = arg;
            fill++;
          end
        end
        blid_pkg::OP_DELETE: begin
          // negative positions and those past the tail leave the list alone
          if (!arg[31] && arg < fill) begin
            for (i = arg; i + 1 < fill; i++) slot[i] = slot[i + 1];
            fill--;
          end else begin
            missed_deletes++;
          end
        end
        default: ;
      endcase
      if (fill > deepest) deepest = fill;
      if (fill == 0) begin
        beat = '{value: 32'sd0, last: 1'b1, empty: 1'b1, dropped: refused};
        expected_beats.push_back(beat);
      end else begin
        for (i = 0; i < fill; i++) begin
          beat = '{value: slot[i], last: (i + 1 == fill), empty: 1'b0,
                   dropped: refused};
          expected_beats.push_back(beat);
        end
      end
    endfunction

    // compare one result transaction with the oldest expected element
    function void check_beat(logic signed [31:0] value, logic last, logic empty,
                             logic dropped);
      list_beat_t want;
      beats_checked++;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value %0d last %0b empty %0b dropped %0b",
                 $time, value, last, empty, dropped);
        return;
      end
      want = expected_beats.pop_front();
      if (value !== want.value || last !== want.last || empty !== want.empty ||
          dropped !== want.dropped) begin
        errors++;
        $display("%0t: mismatch expected value %0d last %0b empty %0b dropped %0b",
                 $time, want.value, want.last, want.empty, want.dropped);
        $display("%0t:          actual   value %0d last %0b empty %0b dropped %0b",
                 $time, value, last, empty, dropped);
      end
    endfunction

    function int outstanding();
      return expected_beats.size();
    endfunction
  endclass

  logic               clk            = 1'b0;
  logic               rst            = 1'b1;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic [1:0]         opcode         = blid_pkg::OP_INS_FRONT;
  logic signed [31:0] operand        = 32'sd0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic signed [31:0] element_value;
  logic               last_element;
  logic               list_empty;
  logic               insert_dropped;

  list_scoreboard sb;
  bit             sending    = 1'b0;
  int             burst_left = 1;
  int             stall_tick = 0;
  int             quiet_cycles = 0;

  bounded_list_insert_delete_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .operand        (operand),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .element_value  (element_value),
    .last_element   (last_element),
    .list_empty     (list_empty),
    .insert_dropped (insert_dropped)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // present one command, hold it until taken, then maybe close the burst
  task automatic send_command(logic [1:0] op, logic signed [31:0] arg);
    opcode   <= op;
    operand  <= arg;
    in_valid <= 1'b1;
    sending   = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.apply_command(op, arg);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      sending   = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
  endtask

  // hold the input side off until every queued element has come out
  task automatic wait_for_drain();
    if (sending) begin
      in_valid <= 1'b0;
      sending   = 1'b0;
    end
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh7FFF_FFFF;
        1:       return 32'sh8000_0000;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // result side: check each transaction, stall in changing moods
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_tick <= 0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_beat(element_value, last_element, list_empty, insert_dropped);
      stall_tick <= stall_tick + 1;
      case ((stall_tick / 256) % 4)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 2) == 0);
        2:       out_stall <= ((stall_tick % 16) < 9);
        default: out_stall <= ($urandom_range(0, 2) != 0);
      endcase
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int                 k;
    int                 issued;
    int                 grow_pct;
    int                 pick;
    logic [1:0]         op;
    logic signed [31:0] arg;
    sb = new();
    burst_left = $urandom_range(1, 12);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // delete on an empty list, at the front and at a negative position
    send_command(blid_pkg::OP_DELETE, 32'sd0);
    send_command(blid_pkg::OP_DELETE, -32'sd1);
    // extremes of the value at both ends
    send_command(blid_pkg::OP_INS_FRONT, 32'sh7FFF_FFFF);
    send_command(blid_pkg::OP_APPEND, 32'sh8000_0000);
    send_command(blid_pkg::OP_INS_FRONT, 32'sd0);
    send_command(blid_pkg::OP_APPEND, -32'sd1);
    send_command(blid_pkg::OP_APPEND, 32'sd1);
    // positions at the count, most negative and largest
    send_command(blid_pkg::OP_DELETE, 32'sd5);
    send_command(blid_pkg::OP_DELETE, 32'sh8000_0000);
    send_command(blid_pkg::OP_DELETE, 32'sh7FFF_FFFF);
    send_command(OP_IDLE, 32'sh5A5A_A5A5);
    // fill the store, then try both kinds of insert on a full store
    for (k = 0; k < 11; k++)
      send_command(k[0] ? blid_pkg::OP_APPEND : blid_pkg::OP_INS_FRONT, $urandom);
    send_command(blid_pkg::OP_INS_FRONT, 32'sh1234_5678);
    send_command(blid_pkg::OP_APPEND, 32'shEDCB_A987);
    // delete at the tail, the front and the middle
    send_command(blid_pkg::OP_DELETE, 32'sd15);
    send_command(blid_pkg::OP_DELETE, 32'sd0);
    send_command(blid_pkg::OP_DELETE, 32'sd7);
    wait_for_drain();

    // random commands, drifting between growing and shrinking the list
    issued   = 0;
    grow_pct = 53;
    while (issued < RANDOM_CMDS) begin
      if (issued % 30 == 0) begin
        case ($urandom_range(0, 2))
          0:       grow_pct = 73;
          1:       grow_pct = 33;
          default: grow_pct = 53;
        endcase
      end
      if (issued > 0 && issued % 90 == 0) wait_for_drain();
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_command(OP_IDLE, $urandom);
      end else begin
        if (pick < grow_pct) begin
          op  = $urandom_range(0, 1) ? blid_pkg::OP_APPEND : blid_pkg::OP_INS_FRONT;
          arg = pick_value();
        end else begin
          op = blid_pkg::OP_DELETE;
          if (sb.fill > 0 && $urandom_range(0, 99) < 85) begin
            arg = $urandom_range(0, sb.fill - 1);
          end else begin
            case ($urandom_range(0, 2))
              0:       arg = sb.fill + $urandom_range(0, 3);
              1:       arg = {1'b1, 31'($urandom)};
              default: arg = $urandom;
            endcase
          end
        end
        send_command(op, arg);
        issued++;
      end
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("commands: %0d front inserts, %0d appends, %0d deletes, %0d no-ops",
             sb.op_seen[blid_pkg::OP_INS_FRONT], sb.op_seen[blid_pkg::OP_APPEND],
             sb.op_seen[blid_pkg::OP_DELETE], sb.op_seen[OP_IDLE]);
    $display("%0d elements checked, %0d inserts refused on a full list, %0d deletes %s %0d",
             sb.beats_checked, sb.dropped_inserts, sb.missed_deletes,
             "outside the list, deepest list", sb.deepest);
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
